// ----- design/ssq_pkg.sv -----
// ----------------------------------------------------------------------------
// ssq_pkg - sustained state qualifier shared definitions
// Field widths, configuration register indexes, mode codes and the
// structures passed between the qualifier core and its update engine.
// ----------------------------------------------------------------------------
package ssq_pkg;

   localparam int TIME_BITS     = 32;
   localparam int MIN_BITS      = 16;
   localparam int MODE_BITS     = 2;
   localparam int CSR_IDX_BITS  = 2;
   localparam int CSR_DATA_BITS = 16;

   localparam int MODE_EITHER_BIT = 1;

   typedef enum logic [MODE_BITS-1:0] {
      MODE_SUSTAIN_TRUE  = 2'd0,
      MODE_SUSTAIN_FALSE = 2'd1,
      MODE_SUSTAIN_ANY   = 2'd2
   } watch_mode_type;

   typedef enum logic [CSR_IDX_BITS-1:0] {
      CSR_WATCH_MODE = 2'd0,
      CSR_MIN_CYCLES = 2'd1
   } csr_index_type;

   typedef struct packed {
      logic [MODE_BITS-1:0] watch_mode;
      logic [MIN_BITS-1:0]  min_cycles;
   } cfg_type;

   typedef struct packed {
      logic                 qualified;
      logic                 flipped;
      logic [TIME_BITS-1:0] change_time;
      logic                 valid_out;
   } result_type;

endpackage

// ----- design/ssq_req_if.sv -----
// ----------------------------------------------------------------------------
// ssq_req_if - request channel
// Valid/ready channel carrying one sampled tick of the watched boolean.
// ----------------------------------------------------------------------------
interface ssq_req_if;
   logic                          valid;
   logic                          ready;
   logic                          watched_level;
   logic                          watched_valid;
   logic [ssq_pkg::TIME_BITS-1:0] timestamp;

   modport source (output valid, output watched_level, output watched_valid,
                   output timestamp, input ready);
   modport sink   (input valid, input watched_level, input watched_valid,
                   input timestamp, output ready);
endinterface

// ----- design/ssq_rsp_if.sv -----
// ----------------------------------------------------------------------------
// ssq_rsp_if - response channel
// Valid/ready channel carrying the qualified state for one tick.
// ----------------------------------------------------------------------------
interface ssq_rsp_if;
   logic                          valid;
   logic                          ready;
   logic                          qualified;
   logic                          flipped;
   logic [ssq_pkg::TIME_BITS-1:0] change_time;
   logic                          valid_out;

   modport source (output valid, output qualified, output flipped,
                   output change_time, output valid_out, input ready);
   modport sink   (input valid, input qualified, input flipped,
                   input change_time, input valid_out, output ready);
endinterface

// ----- design/ssq_engine.sv -----
// ----------------------------------------------------------------------------
// ssq_engine - persistence state update
// Holds the persistence counter, target level and qualified state and
// works out the next state and the response fields for each transaction.
// ----------------------------------------------------------------------------
module ssq_engine #(
   parameter int COUNT_WIDTH = 16,
   parameter int TIME_WIDTH  = 32
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          accept,
   input  logic                          level,
   input  logic                          level_valid,
   input  logic [ssq_pkg::TIME_BITS-1:0] now,
   input  ssq_pkg::cfg_type              cfg,
   output ssq_pkg::result_type           result
);

   localparam int TB     = ssq_pkg::TIME_BITS;
   localparam int TKEEP  = (TIME_WIDTH < TB) ? TIME_WIDTH : TB;
   localparam int CMP_W  = (COUNT_WIDTH > ssq_pkg::MIN_BITS) ? COUNT_WIDTH
                                                              : ssq_pkg::MIN_BITS;

   logic [COUNT_WIDTH-1:0] count_ff, count_in;
   logic                   target_ff, target_in;
   logic                   qualified_ff, qualified_in;
   logic                   flipped_ff, flipped_in;
   logic                   valid_prev_ff, valid_prev_in;
   logic                   first_tick_ff, first_tick_in;
   logic [TKEEP-1:0]       time_ff, time_in;

   logic                   either;
   logic                   target_now;
   logic [CMP_W-1:0]       min_ext, cnt_max_ext, limit_ext, count_ext;
   logic [CMP_W:0]         inc;
   logic [CMP_W-1:0]       count_next_ext;
   logic [COUNT_WIDTH-1:0] count_next;
   logic                   q_next, flip_next;

   always_comb begin
      either      = cfg.watch_mode[ssq_pkg::MODE_EITHER_BIT];
      target_now  = first_tick_ff
                    ? (either ? level
                              : (cfg.watch_mode == ssq_pkg::MODE_SUSTAIN_TRUE))
                    : target_ff;
      min_ext     = CMP_W'(cfg.min_cycles);
      cnt_max_ext = CMP_W'({COUNT_WIDTH{1'b1}});
      limit_ext   = (min_ext > cnt_max_ext) ? cnt_max_ext : min_ext;
      count_ext   = CMP_W'(count_ff);
      inc         = {1'b0, count_ext} + (CMP_W+1)'(1);
      if (level == target_now) begin
         count_next_ext = (inc > {1'b0, limit_ext}) ? limit_ext : inc[CMP_W-1:0];
      end else begin
         count_next_ext = '0;
      end
      count_next = count_next_ext[COUNT_WIDTH-1:0];
      q_next     = (count_next_ext >= min_ext);
      flip_next  = (q_next != qualified_ff);

      count_in      = count_ff;
      qualified_in  = qualified_ff;
      flipped_in    = flipped_ff;
      target_in     = target_now;
      time_in       = time_ff;
      valid_prev_in = level_valid;
      first_tick_in = 1'b0;
      if (level_valid) begin
         count_in     = count_next;
         qualified_in = q_next;
         flipped_in   = flip_next;
         if (flip_next && either) begin
            target_in = level;
         end
         if (flip_next || (level_valid != valid_prev_ff) || first_tick_ff) begin
            time_in = now[TKEEP-1:0];
         end
      end

      result.qualified   = qualified_in;
      result.flipped     = flipped_in;
      result.change_time = TB'(time_in);
      result.valid_out   = level_valid;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff      <= '0;
         target_ff     <= 1'b0;
         qualified_ff  <= 1'b0;
         flipped_ff    <= 1'b0;
         valid_prev_ff <= 1'b1;
         first_tick_ff <= 1'b1;
         time_ff       <= '0;
      end else if (accept) begin
         count_ff      <= count_in;
         target_ff     <= target_in;
         qualified_ff  <= qualified_in;
         flipped_ff    <= flipped_in;
         valid_prev_ff <= valid_prev_in;
         first_tick_ff <= first_tick_in;
         time_ff       <= time_in;
      end
   end

`ifndef NO_ASSERTIONS
   a_first_tick_on_accept: assert property (@(posedge clock) disable iff (reset)
      $fell(first_tick_ff) |-> $past(accept))
      else $error("first tick cleared without a transaction");

   a_invalid_holds: assert property (@(posedge clock) disable iff (reset)
      (accept && !level_valid) |=> ($stable(qualified_ff) && $stable(count_ff)
                                    && $stable(flipped_ff)))
      else $error("state moved on an invalid tick");

   a_flip_tracks: assert property (@(posedge clock) disable iff (reset)
      (accept && level_valid) |=> (flipped_ff == (qualified_ff != $past(qualified_ff))))
      else $error("flip flag does not match qualified change");
`endif

endmodule

// ----- design/sustained_state_qualifier_core.sv -----
// ----------------------------------------------------------------------------
// sustained_state_qualifier_core - persistence debounce qualifier
// Qualifies a watched boolean once it has held its target level for a
// configured number of valid ticks, and tracks the time of the last change.
// ----------------------------------------------------------------------------
// The response is registered: response valid rises in the cycle after the
// request transaction. Throughput: one transaction per cycle; back-pressure
// on the response channel alone stalls it.
// Reset: synchronous; clears the counter, qualified, flipped and response
// valid, arms first-tick target capture, sets watch_mode 0 and min_cycles 1.
module sustained_state_qualifier_core #(
   parameter int COUNT_WIDTH = 16,
   parameter int TIME_WIDTH  = 32
) (
   input  logic                              clock,
   input  logic                              reset,
   ssq_req_if.sink                           req_chan,
   ssq_rsp_if.source                         rsp_chan,
   input  logic                              csr_we,
   input  logic [ssq_pkg::CSR_IDX_BITS-1:0]  csr_index,
   input  logic [ssq_pkg::CSR_DATA_BITS-1:0] csr_wdata
);

   ssq_pkg::cfg_type    cfg_ff;
   ssq_pkg::result_type eng_result;
   ssq_pkg::result_type rsp_data_ff;
   logic                rsp_valid_ff;
   logic                accept;

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.watch_mode <= ssq_pkg::MODE_SUSTAIN_TRUE;
         cfg_ff.min_cycles <= ssq_pkg::MIN_BITS'(1);
      end else if (csr_we) begin
         unique case (ssq_pkg::csr_index_type'(csr_index))
            ssq_pkg::CSR_WATCH_MODE: begin
               cfg_ff.watch_mode <= csr_wdata[ssq_pkg::MODE_BITS-1:0];
            end
            ssq_pkg::CSR_MIN_CYCLES: begin
               cfg_ff.min_cycles <= csr_wdata[ssq_pkg::MIN_BITS-1:0];
            end
            default: begin
            end
         endcase
      end
   end

   assign req_chan.ready = !rsp_valid_ff || rsp_chan.ready;
   assign accept         = req_chan.valid && req_chan.ready && !reset;

   ssq_engine #(
      .COUNT_WIDTH (COUNT_WIDTH),
      .TIME_WIDTH  (TIME_WIDTH)
   ) u_engine (
      .clock       (clock),
      .reset       (reset),
      .accept      (accept),
      .level       (req_chan.watched_level),
      .level_valid (req_chan.watched_valid),
      .now         (req_chan.timestamp),
      .cfg         (cfg_ff),
      .result      (eng_result)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (accept) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_chan.ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         rsp_data_ff <= eng_result;
      end
   end

   assign rsp_chan.valid       = rsp_valid_ff;
   assign rsp_chan.qualified   = rsp_data_ff.qualified;
   assign rsp_chan.flipped     = rsp_data_ff.flipped;
   assign rsp_chan.change_time = rsp_data_ff.change_time;
   assign rsp_chan.valid_out   = rsp_data_ff.valid_out;

`ifndef NO_ASSERTIONS
   a_no_accept_when_full: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && !rsp_chan.ready) |-> !req_chan.ready)
      else $error("request taken while response stalled");

   a_accept_gives_rsp: assert property (@(posedge clock) disable iff (reset)
      accept |=> rsp_valid_ff)
      else $error("transaction produced no response");

   a_drain_only_on_ready: assert property (@(posedge clock) disable iff (reset)
      $fell(rsp_valid_ff) |-> $past(rsp_chan.ready))
      else $error("response dropped without being taken");
`endif

endmodule

// ----- sim/testbench.sv -----
// ----------------------------------------------------------------------------
// testbench - sustained state qualifier core
// Streams ticks of a watched boolean into the core and checks every response
// against a cycle-free model of the persistence counter, target capture and
// change-time tracking, over a spread of watch modes and minimum run lengths,
// with random stalls on both channels.
// ----------------------------------------------------------------------------
module testbench;

   localparam int COUNT_W     = 16;
   localparam int CYCLE_LIMIT = 200000;
   localparam int PHASES      = 12;
   localparam int PHASE_TICKS = 50;

   typedef struct {
      logic                          level;
      logic                          valid;
      logic [ssq_pkg::TIME_BITS-1:0] stamp;
   } tick_type;

   logic                              clock = 1'b0;
   logic                              reset;
   logic                              csr_we;
   logic [ssq_pkg::CSR_IDX_BITS-1:0]  csr_index;
   logic [ssq_pkg::CSR_DATA_BITS-1:0] csr_wdata;

   ssq_req_if req_if ();
   ssq_rsp_if rsp_if ();

   sustained_state_qualifier_core #(
      .COUNT_WIDTH (COUNT_W),
      .TIME_WIDTH  (ssq_pkg::TIME_BITS)
   ) dut (
      .clock     (clock),
      .reset     (reset),
      .req_chan  (req_if),
      .rsp_chan  (rsp_if),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   tick_type            pending_ticks[$];
   ssq_pkg::result_type expected_results[$];

   int send_idle_pct = 0;
   int recv_idle_pct = 0;
   int queued_count = 0;
   int accepted_count = 0;
   int checked_count = 0;
   int mismatch_count = 0;
   int cycle_count = 0;
   int settings_count = 0;

   logic [ssq_pkg::TIME_BITS-1:0] stamp_base;

   // qualifier model state and register shadow
   ssq_pkg::cfg_type              cfg_shadow;
   logic [COUNT_W-1:0]            persist;
   logic                          target_lvl;
   logic                          qual_state;
   logic                          flip_state;
   logic                          valid_last;
   logic                          first_pending;
   logic [ssq_pkg::TIME_BITS-1:0] ctime_state;

   always #5 clock = ~clock;

   function automatic ssq_pkg::result_type advance_qualifier(tick_type t);
      ssq_pkg::result_type r;
      logic                either;
      logic                was_first;
      logic                valid_moved;
      logic                prev_q;
      logic [COUNT_W-1:0]  lim;
      logic [COUNT_W:0]    nxt;
      either      = cfg_shadow.watch_mode[ssq_pkg::MODE_EITHER_BIT];
      was_first   = first_pending;
      valid_moved = (t.valid != valid_last);
      if (first_pending) begin
         target_lvl = either ? t.level
                             : (cfg_shadow.watch_mode == ssq_pkg::MODE_SUSTAIN_TRUE);
         first_pending = 1'b0;
      end
      valid_last = t.valid;
      if (t.valid) begin
         prev_q = qual_state;
         lim = cfg_shadow.min_cycles;
         if (t.level == target_lvl) begin
            nxt = {1'b0, persist} + 1'b1;
            persist = (nxt > {1'b0, lim}) ? lim : nxt[COUNT_W-1:0];
         end else begin
            persist = '0;
         end
         qual_state = (persist >= cfg_shadow.min_cycles);
         flip_state = (qual_state != prev_q);
         if (flip_state && either) begin
            target_lvl = t.level;
         end
         if (flip_state || valid_moved || was_first) begin
            ctime_state = t.stamp;
         end
      end
      r.qualified   = qual_state;
      r.flipped     = flip_state;
      r.change_time = ctime_state;
      r.valid_out   = t.valid;
      return r;
   endfunction

   function automatic logic [ssq_pkg::TIME_BITS-1:0] next_stamp();
      stamp_base = stamp_base + $urandom_range(1, 4);
      return ($urandom_range(19) == 0) ? $urandom : stamp_base;
   endfunction

   task automatic queue_tick(logic level, logic valid,
                             logic [ssq_pkg::TIME_BITS-1:0] stamp);
      tick_type t;
      t.level = level;
      t.valid = valid;
      t.stamp = stamp;
      pending_ticks = {pending_ticks, t};
      queued_count++;
   endtask

   // runs of one level near the minimum length, mostly valid; some noise
   task automatic queue_random_ticks(int n);
      int   left;
      int   run_len;
      int   run_cap;
      logic lvl;
      left = n;
      run_cap = (cfg_shadow.min_cycles > 9) ? 12 : int'(cfg_shadow.min_cycles) + 3;
      while (left > 0) begin
         lvl = 1'($urandom_range(1));
         if ($urandom_range(9) == 0) begin
            run_len = $urandom_range(1, 3);
            for (int i = 0; i < run_len; i++) begin
               queue_tick(1'($urandom_range(1)), 1'($urandom_range(1)), next_stamp());
            end
         end else begin
            run_len = $urandom_range(1, run_cap);
            for (int i = 0; i < run_len; i++) begin
               queue_tick(lvl, $urandom_range(99) >= 10, next_stamp());
            end
         end
         left -= run_len;
      end
   endtask

   task automatic write_csr(ssq_pkg::csr_index_type idx,
                            logic [ssq_pkg::CSR_DATA_BITS-1:0] data);
      @(posedge clock);
      csr_we    <= 1'b1;
      csr_index <= idx;
      csr_wdata <= data;
      @(posedge clock);
      csr_we <= 1'b0;
      if (idx == ssq_pkg::CSR_WATCH_MODE) begin
         cfg_shadow.watch_mode = data[ssq_pkg::MODE_BITS-1:0];
      end else begin
         cfg_shadow.min_cycles = data;
      end
   endtask

   task automatic apply_settings(logic [ssq_pkg::MODE_BITS-1:0] mode,
                                 logic [ssq_pkg::MIN_BITS-1:0] min_len);
      write_csr(ssq_pkg::CSR_WATCH_MODE,
                {{(ssq_pkg::CSR_DATA_BITS-ssq_pkg::MODE_BITS){1'b0}}, mode});
      write_csr(ssq_pkg::CSR_MIN_CYCLES, min_len);
      settings_count++;
   endtask

   task automatic drain();
      while (accepted_count != queued_count || expected_results.size() != 0) begin
         @(posedge clock);
      end
   endtask

   // driver
   always @(posedge clock) begin : driver
      tick_type t;
      if (reset) begin
         req_if.valid         <= 1'b0;
         req_if.watched_level <= 1'b0;
         req_if.watched_valid <= 1'b0;
         req_if.timestamp     <= '0;
      end else if (!req_if.valid || req_if.ready) begin
         if (pending_ticks.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
            t = pending_ticks.pop_front();
            req_if.valid         <= 1'b1;
            req_if.watched_level <= t.level;
            req_if.watched_valid <= t.valid;
            req_if.timestamp     <= t.stamp;
         end else begin
            req_if.valid <= 1'b0;
         end
      end
   end

   always @(posedge clock) begin
      rsp_if.ready <= ($urandom_range(99) >= recv_idle_pct);
   end

   // monitor: check the response transaction, then predict the request one
   always @(posedge clock) begin : monitor
      ssq_pkg::result_type got;
      ssq_pkg::result_type want;
      tick_type            t;
      if (reset) begin
         persist       = '0;
         target_lvl    = 1'b0;
         qual_state    = 1'b0;
         flip_state    = 1'b0;
         valid_last    = 1'b1;
         first_pending = 1'b1;
         ctime_state   = '0;
      end else begin
         if (rsp_if.valid && rsp_if.ready) begin
            got.qualified   = rsp_if.qualified;
            got.flipped     = rsp_if.flipped;
            got.change_time = rsp_if.change_time;
            got.valid_out   = rsp_if.valid_out;
            if (expected_results.size() == 0) begin
               mismatch_count++;
               if (mismatch_count <= 10) begin
                  $display("unexpected response: q=%0b f=%0b t=%08h v=%0b",
                           got.qualified, got.flipped, got.change_time, got.valid_out);
               end
            end else begin
               want = expected_results.pop_front();
               if (got.qualified !== want.qualified || got.flipped !== want.flipped ||
                   got.change_time !== want.change_time ||
                   got.valid_out !== want.valid_out) begin
                  mismatch_count++;
                  if (mismatch_count <= 10) begin
                     $display("response %0d: expected q=%0b f=%0b t=%08h v=%0b,",
                              checked_count, want.qualified, want.flipped,
                              want.change_time, want.valid_out);
                     $display("   got q=%0b f=%0b t=%08h v=%0b",
                              got.qualified, got.flipped, got.change_time,
                              got.valid_out);
                  end
               end
               checked_count++;
            end
         end
         if (req_if.valid && req_if.ready) begin
            t.level = req_if.watched_level;
            t.valid = req_if.watched_valid;
            t.stamp = req_if.timestamp;
            want = advance_qualifier(t);
            expected_results = {expected_results, want};
            accepted_count++;
         end
      end
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("timeout after %0d cycles", cycle_count);
         $display("** sustained_state_qualifier_core: FAILED **");
         $finish;
      end
   end

   initial begin : stimulus
      logic [ssq_pkg::MODE_BITS-1:0] mode_list [PHASES];
      logic [ssq_pkg::MIN_BITS-1:0]  min_list  [PHASES];
      mode_list = '{ssq_pkg::MODE_SUSTAIN_TRUE, ssq_pkg::MODE_SUSTAIN_FALSE,
                    ssq_pkg::MODE_SUSTAIN_ANY, 2'd3, ssq_pkg::MODE_SUSTAIN_ANY,
                    ssq_pkg::MODE_SUSTAIN_TRUE, ssq_pkg::MODE_SUSTAIN_FALSE,
                    ssq_pkg::MODE_SUSTAIN_ANY, 2'd3, ssq_pkg::MODE_SUSTAIN_ANY,
                    ssq_pkg::MODE_SUSTAIN_TRUE, ssq_pkg::MODE_SUSTAIN_FALSE};
      min_list  = '{16'd1, 16'd0, 16'd2, 16'd4, 16'hFFFF, 16'd5,
                    16'd2, 16'd0, 16'd1, 16'd3, 16'hFFFF, 16'd3};
      reset                = 1'b1;
      csr_we               = 1'b0;
      csr_index            = ssq_pkg::CSR_WATCH_MODE;
      csr_wdata            = '0;
      cfg_shadow.watch_mode = ssq_pkg::MODE_SUSTAIN_TRUE;
      cfg_shadow.min_cycles = 16'd1;
      stamp_base    = $urandom;
      repeat (6) @(posedge clock);
      reset <= 1'b0;

      // target captured on an invalid first tick, then runs of each level
      apply_settings(ssq_pkg::MODE_SUSTAIN_ANY, 16'd3);
      queue_tick(1'b1, 1'b0, 32'hFFFF_FFFF);
      queue_tick(1'b1, 1'b1, 32'h0000_0000);
      queue_tick(1'b1, 1'b1, 32'hAAAA_AAAA);
      queue_tick(1'b1, 1'b1, 32'h5555_5555);
      queue_tick(1'b1, 1'b1, 32'h0000_0004);
      queue_tick(1'b0, 1'b0, 32'h0000_0005);
      queue_tick(1'b0, 1'b1, 32'h0000_0006);
      queue_tick(1'b0, 1'b1, 32'h0000_0007);
      queue_tick(1'b0, 1'b1, 32'h0000_0008);
      queue_tick(1'b0, 1'b1, 32'h8000_0000);
      queue_tick(1'b1, 1'b0, 32'h7FFF_FFFF);
      queue_tick(1'b1, 1'b1, 32'hFFFF_FFFE);
      drain();
      // zero minimum: qualified on every valid tick
      apply_settings(ssq_pkg::MODE_SUSTAIN_TRUE, 16'd0);
      queue_tick(1'b0, 1'b1, 32'h0000_0010);
      queue_tick(1'b1, 1'b1, 32'h0000_0011);
      queue_tick(1'b0, 1'b0, 32'h0000_0012);
      queue_tick(1'b1, 1'b1, 32'h0000_0013);
      drain();
      // mode value three behaves as either-level
      apply_settings(2'd3, 16'd1);
      queue_tick(1'b0, 1'b1, 32'h0000_0020);
      queue_tick(1'b1, 1'b1, 32'h0000_0021);
      queue_tick(1'b1, 1'b1, 32'h0000_0022);
      queue_tick(1'b0, 1'b1, 32'h0000_0023);
      drain();
      apply_settings(ssq_pkg::MODE_SUSTAIN_FALSE, 16'hFFFF);
      queue_tick(1'b0, 1'b1, 32'h0000_0030);
      queue_tick(1'b0, 1'b1, 32'h0000_0031);
      queue_tick(1'b1, 1'b0, 32'h0000_0032);
      queue_tick(1'b0, 1'b1, 32'h0000_0033);
      drain();

      for (int p = 0; p < PHASES; p++) begin
         if (p < PHASES / 3) begin
            send_idle_pct = 20;
            recv_idle_pct = 83;
         end else if (p < 2 * PHASES / 3) begin
            send_idle_pct = 83;
            recv_idle_pct = 20;
         end else begin
            send_idle_pct = 0;
            recv_idle_pct = 0;
         end
         apply_settings(mode_list[p], min_list[p]);
         queue_random_ticks(PHASE_TICKS / 2);
         // sender holds off until the core has answered everything
         drain();
         queue_random_ticks(PHASE_TICKS - PHASE_TICKS / 2);
         drain();
      end

      repeat (4) @(posedge clock);
      $display("%0d ticks checked across %0d register settings (modes 0-3, minimum 0-65535),",
               checked_count, settings_count);
      $display("with stalls on either channel and none; %0d mismatches", mismatch_count);
      if (mismatch_count == 0 && expected_results.size() == 0) begin
         $display("** sustained_state_qualifier_core: PASSED **");
      end else begin
         $display("** sustained_state_qualifier_core: FAILED **");
      end
      $finish;
   end

endmodule

// ----- filelist.f -----
design/ssq_pkg.sv
design/ssq_req_if.sv
design/ssq_rsp_if.sv
design/ssq_engine.sv
design/sustained_state_qualifier_core.sv
sim/testbench.sv
